// ===== src/sorted_set_jaccard_similarity_unit_defines.svh =====
// assertion macros for the jaccard similarity unit checker
`ifndef SORTED_SET_JACCARD_SIMILARITY_UNIT_DEFINES_SVH
`define SORTED_SET_JACCARD_SIMILARITY_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define JSU_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jaccard unit check failed");

// next-cycle implication, sampled on clk, off during reset
`define JSU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jaccard unit check failed");

`endif

// ===== src/jsu_pkg.sv =====
// shared constants, codes and types of the jaccard similarity unit
package jsu_pkg;

	localparam int MAX_DEGREE  = 256;
	localparam int VERTEX_BITS = 16;

	localparam int LEN_W      = $clog2(MAX_DEGREE + 1);
	localparam int ADDR_W     = $clog2(MAX_DEGREE);
	localparam int CMD_W      = 2;
	localparam int VERTEX_W   = 16;
	localparam int COMMON_W   = 9;
	localparam int UNION_W    = 10;
	localparam int PROD_W     = 17;
	localparam int RATIO_W    = 17;
	localparam int FRAC_BITS  = 16;
	localparam int DIVIDEND_W = COMMON_W + FRAC_BITS;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

	localparam logic [CMD_W-1:0] CMD_APPEND_FIRST  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND_SECOND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE       = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [UNION_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [RATIO_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic [COMMON_W-1:0] common_count;
		logic [UNION_W-1:0]  union_count;
		logic [PROD_W-1:0]   degree_product;
		logic [RATIO_W-1:0]  jaccard_ratio;
		logic                empty_union;
		logic                overflowed;
	} out_word_t;

endpackage

// ===== src/jsu_in_if.sv =====
// request channel: command and vertex words
interface jsu_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] vertex;

	modport source (output valid, output cmd, output vertex, input ready);
	modport sink   (input valid, input cmd, input vertex, output ready);
endinterface

// ===== src/jsu_out_if.sv =====
// result channel: similarity words
interface jsu_out_if;
	logic        valid;
	logic        ready;
	logic [8:0]  common_count;
	logic [9:0]  union_count;
	logic [16:0] degree_product;
	logic [16:0] jaccard_ratio;
	logic        empty_union;
	logic        overflowed;

	modport source (output valid, output common_count, output union_count,
		output degree_product, output jaccard_ratio, output empty_union,
		output overflowed, input ready);
	modport sink   (input valid, input common_count, input union_count,
		input degree_product, input jaccard_ratio, input empty_union,
		input overflowed, output ready);
endinterface

// ===== src/jsu_divider.sv =====
// restoring divider, one quotient bit per cycle
module jsu_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  jsu_pkg::div_req_t req,
	output jsu_pkg::div_rsp_t rsp
);
	import jsu_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  count_q;
	logic [UNION_W-1:0]    rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [UNION_W-1:0]    divisor_q;

	logic [UNION_W:0]   rem_sh;
	logic               fits;
	logic [UNION_W-1:0] rem_nx;

	always_comb begin
		rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
		fits   = rem_sh >= {1'b0, divisor_q};
		rem_nx = fits ? UNION_W'(rem_sh - {1'b0, divisor_q}) : rem_sh[UNION_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else if (req.start) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			count_q <= '0;
		end else if (busy_q) begin
			count_q <= count_q + 1'b1;
			if (count_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	always_comb begin
		rsp.done     = done_q;
		rsp.quotient = quo_q[RATIO_W-1:0];
	end

endmodule

// ===== src/sorted_set_jaccard_similarity_unit.sv =====
// top level of the sorted-list jaccard similarity unit
// Appends (cmd 0 and 1) are taken one per cycle while the unit is idle and
// written into two 256-entry list memories; a full list drops the word and
// raises the overflow flag. A compute word (cmd 2) starts a two-pointer walk
// that reads both list memories once per cycle, one step per cycle, and stops
// when either list runs out. The ratio then comes from a bit-serial divider
// that computes 25 quotient bits, skipped when both lists are empty, and the
// word is then handed to the output register, where the lists are cleared.
// While a compute runs, and while the word waits for the output register
// to empty, no request word is taken. A result waiting in the output
// register does not stop appends.
module sorted_set_jaccard_similarity_unit (
	input  logic clk,
	input  logic arst_n,
	jsu_in_if.sink    request,
	jsu_out_if.source result
);
	import jsu_pkg::*;

	state_t state_q, state_d;

	logic [LEN_W-1:0] len_a_q, len_b_q;
	logic             ovf_q;
	logic             out_valid_q;
	out_word_t        out_word_q;

	logic [LEN_W-1:0]    ptr_a_q, ptr_b_q;
	logic [COMMON_W-1:0] common_q;
	logic [UNION_W-1:0]  union_q;
	logic [PROD_W-1:0]   product_q;
	logic [RATIO_W-1:0]  ratio_q;
	logic                empty_q;

	logic [VERTEX_BITS-1:0] mem_a [MAX_DEGREE];
	logic [VERTEX_BITS-1:0] mem_b [MAX_DEGREE];
	logic [VERTEX_BITS-1:0] rd_a_q, rd_b_q;

	logic                   accept;
	logic [VERTEX_BITS-1:0] vtx;
	logic                   we_a, we_b, full_a, full_b;
	logic                   walk_more, hit, adv_a, adv_b;
	logic [LEN_W-1:0]       ptr_a_nx, ptr_b_nx;
	logic [UNION_W-1:0]     union_sum;
	logic [2*LEN_W-1:0]     prod_full;
	logic                   walk_end, out_load;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	jsu_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		accept    = request.valid && request.ready;
		vtx       = request.vertex[VERTEX_BITS-1:0];
		full_a    = !(len_a_q < LEN_W'(MAX_DEGREE));
		full_b    = !(len_b_q < LEN_W'(MAX_DEGREE));
		we_a      = accept && (request.cmd == CMD_APPEND_FIRST) && !full_a;
		we_b      = accept && (request.cmd == CMD_APPEND_SECOND) && !full_b;
		walk_more = (ptr_a_q < len_a_q) && (ptr_b_q < len_b_q);
		hit       = rd_a_q == rd_b_q;
		adv_a     = walk_more && (hit || (rd_a_q < rd_b_q));
		adv_b     = walk_more && (hit || (rd_a_q > rd_b_q));
		if (state_q == ST_WALK) begin
			ptr_a_nx = ptr_a_q + LEN_W'(adv_a);
			ptr_b_nx = ptr_b_q + LEN_W'(adv_b);
		end else begin
			ptr_a_nx = '0;
			ptr_b_nx = '0;
		end
		union_sum = UNION_W'(len_a_q) + UNION_W'(len_b_q) - UNION_W'(common_q);
		prod_full = len_a_q * len_b_q;
		walk_end  = (state_q == ST_WALK) && !walk_more;
		out_load  = (state_q == ST_DONE) && (!out_valid_q || result.ready);
		div_req.start    = walk_end && (union_sum != '0);
		div_req.dividend = {common_q, {FRAC_BITS{1'b0}}};
		div_req.divisor  = union_sum;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (request.cmd == CMD_COMPUTE)) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (!walk_more) state_d = (union_sum == '0) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		request.ready         = (state_q == ST_IDLE);
		result.valid          = out_valid_q;
		result.common_count   = out_word_q.common_count;
		result.union_count    = out_word_q.union_count;
		result.degree_product = out_word_q.degree_product;
		result.jaccard_ratio  = out_word_q.jaccard_ratio;
		result.empty_union    = out_word_q.empty_union;
		result.overflowed     = out_word_q.overflowed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_a_q     <= '0;
			len_b_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				len_a_q <= '0;
				len_b_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (we_a) len_a_q <= len_a_q + 1'b1;
				if (we_b) len_b_q <= len_b_q + 1'b1;
				if (accept && (request.cmd == CMD_APPEND_FIRST) && full_a) ovf_q <= 1'b1;
				if (accept && (request.cmd == CMD_APPEND_SECOND) && full_b) ovf_q <= 1'b1;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	// walk, totals and result word
	always_ff @(posedge clk) begin
		ptr_a_q <= ptr_a_nx;
		ptr_b_q <= ptr_b_nx;
		if (state_q == ST_IDLE) common_q <= '0;
		else if (state_q == ST_WALK && walk_more && hit) common_q <= common_q + 1'b1;
		if (walk_end) begin
			union_q   <= union_sum;
			product_q <= prod_full[PROD_W-1:0];
			empty_q   <= (union_sum == '0);
			ratio_q   <= '0;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			ratio_q <= div_rsp.quotient;
		end
		if (out_load) begin
			out_word_q.common_count   <= common_q;
			out_word_q.union_count    <= union_q;
			out_word_q.degree_product <= product_q;
			out_word_q.jaccard_ratio  <= ratio_q;
			out_word_q.empty_union    <= empty_q;
			out_word_q.overflowed     <= ovf_q;
		end
	end

	// list memories, read address follows the next pointer
	always_ff @(posedge clk) begin
		if (we_a) mem_a[len_a_q[ADDR_W-1:0]] <= vtx;
		if (we_b) mem_b[len_b_q[ADDR_W-1:0]] <= vtx;
		rd_a_q <= mem_a[ptr_a_nx[ADDR_W-1:0]];
		rd_b_q <= mem_b[ptr_b_nx[ADDR_W-1:0]];
	end

endmodule

// ===== src/jsu_checker.sv =====
// port-level checks of the jaccard similarity unit and their bind
`include "sorted_set_jaccard_similarity_unit_defines.svh"

module jsu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_cmd,
	input logic        res_valid,
	input logic        res_ready,
	input logic [8:0]  common_count,
	input logic [9:0]  union_count,
	input logic [16:0] jaccard_ratio,
	input logic        empty_union
);
	import jsu_pkg::*;

	// a stalled result word keeps its ratio
	`JSU_ASSERT_NEXT(res_hold_a, res_valid && !res_ready, res_valid && $stable(jaccard_ratio))

	// a compute word closes the request side at once
	`JSU_ASSERT_NEXT(busy_after_compute_a, req_valid && req_ready && req_cmd == CMD_COMPUTE, !req_ready)

	// empty union gives a zero ratio and zero union and common counts
	`JSU_ASSERT_IMPL(empty_zero_a, res_valid && empty_union, jaccard_ratio == '0 && union_count == '0 && common_count == '0)

	// matches never exceed the union and the ratio stays within one
	`JSU_ASSERT_IMPL(ratio_range_a, res_valid && !empty_union, {1'b0, common_count} <= union_count && jaccard_ratio <= 17'd65536)

endmodule

bind sorted_set_jaccard_similarity_unit jsu_checker u_jsu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (request.valid),
	.req_ready     (request.ready),
	.req_cmd       (request.cmd),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.common_count  (result.common_count),
	.union_count   (result.union_count),
	.jaccard_ratio (result.jaccard_ratio),
	.empty_union   (result.empty_union)
);
